// File: src/f2p_pkg.sv
`timescale 1ns / 1ps

package f2p_pkg;

  // Scaling modes, chosen per item from the configuration.
  localparam logic [1:0] MODE_ZERO = 2'd0;
  localparam logic [1:0] MODE_16   = 2'd1;
  localparam logic [1:0] MODE_24   = 2'd2;
  localparam logic [1:0] MODE_32   = 2'd3;

  // Configuration register indexes.
  localparam logic REG_SUBFRAME_SIZE = 1'b0;
  localparam logic REG_BIT_DEPTH     = 1'b1;

  localparam logic [2:0] SIZE_RESET  = 3'd2;
  localparam logic [5:0] DEPTH_RESET = 6'd16;
  localparam logic [7:0] EXP_ONE     = 8'd127;
  localparam logic [7:0] EXP_SPECIAL = 8'd255;

  typedef struct packed {
    logic        sgn;
    logic [7:0]  expo;
    logic [23:0] mant;
    logic [1:0]  mode;
    logic        last;
  } dec_t;

  typedef struct packed {
    logic        sgn;
    logic [7:0]  expo;
    logic [55:0] prod;
    logic [1:0]  mode;
    logic        last;
  } mul_t;

  typedef struct packed {
    logic              sgn;
    logic [24:0]       rmant;
    logic signed [9:0] shamt;
    logic [1:0]        mode;
    logic              last;
  } rnd_t;

  // Full-scale multiplier of each mode, as an integer (all are exact in single precision).
  function automatic logic [31:0] scale_k(input logic [1:0] mode);
    logic [31:0] k;
    begin
      unique case (mode)
        MODE_16: k = 32'd32767;
        MODE_24: k = 32'd8388607;
        MODE_32: k = 32'h8000_0000;
        default: k = 32'd0;
      endcase
      return k;
    end
  endfunction

  // Position of the leading one of the multiplier.
  function automatic logic [4:0] scale_bit(input logic [1:0] mode);
    logic [4:0] b;
    begin
      unique case (mode)
        MODE_16: b = 5'd14;
        MODE_24: b = 5'd22;
        MODE_32: b = 5'd31;
        default: b = 5'd14;
      endcase
      return b;
    end
  endfunction

endpackage

// File: src/float_to_pcm_sample_converter_core.sv
`timescale 1ns / 1ps

// Float to PCM sample converter.
// Input stream (s_*): one single-precision audio sample per transfer in s_tdata,
// with s_tlast marking the last channel sample of a frame.
// Output stream (m_*): the PCM subframe as a little-endian byte image in
// m_tdata (only the low subframe_size bytes are meaningful, the rest are zero),
// with m_tlast copied from the input.
// Configuration is written through cfg_we / cfg_index / cfg_data while the
// stream is idle: index 0 is subframe_size, index 1 is bit_depth.
// There are four register stages: decode and clamp, 24x32 multiply, round to
// single precision, then scale shift and packing. The first stage loads at the
// input transfer; the later stages follow in turn. Throughput is one sample
// per cycle when not stalled; all four stages advance together.
// When the receiver stalls, the whole pipeline holds and s_tready falls,
// so nothing is lost or repeated; the output register keeps its data stable.
// Reset clears every stage valid and loads subframe_size = 2, bit_depth = 16.
module float_to_pcm_sample_converter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample_float
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] pcm_word
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data
);

  logic [2:0]    subframe_size;
  logic [5:0]    bit_depth;
  logic          en;
  logic          dec_valid;
  logic          mul_valid;
  logic          rnd_valid;
  f2p_pkg::dec_t dec;
  f2p_pkg::mul_t mul;
  f2p_pkg::rnd_t rnd;

  // The pipeline moves whenever the output register is empty or being taken.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      subframe_size <= f2p_pkg::SIZE_RESET;
      bit_depth     <= f2p_pkg::DEPTH_RESET;
    end else if (cfg_we) begin
      if (cfg_index == f2p_pkg::REG_SUBFRAME_SIZE) begin
        subframe_size <= cfg_data[2:0];
      end else begin
        bit_depth <= cfg_data;
      end
    end
  end

  f2p_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (s_tvalid),
    .sample        (s_tdata),
    .last          (s_tlast),
    .subframe_size (subframe_size),
    .bit_depth     (bit_depth),
    .out_valid     (dec_valid),
    .dec           (dec)
  );

  f2p_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dec_valid),
    .dec       (dec),
    .out_valid (mul_valid),
    .mul       (mul)
  );

  f2p_round u_round (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (mul_valid),
    .mul       (mul),
    .out_valid (rnd_valid),
    .rnd       (rnd)
  );

  f2p_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (rnd_valid),
    .rnd       (rnd),
    .out_valid (m_tvalid),
    .pcm_word  (m_tdata),
    .last      (m_tlast)
  );

  // The output is empty straight after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid straight after reset");

  // A valid rounded item reaches the output when the pipeline advances.
  a_advance: assert property (@(posedge clk) disable iff (rst)
    rnd_valid && en |=> m_tvalid)
    else $error("item lost between rounding and output");

  // A 16-bit subframe leaves the upper two bytes clear.
  a_mode16: assert property (@(posedge clk) disable iff (rst)
    rnd_valid && en && rnd.mode == f2p_pkg::MODE_16 |=> m_tdata[31:16] == 16'd0)
    else $error("upper bytes set on a 16-bit subframe");

  // Unsupported sizes and subnormal inputs give an all-zero word.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    rnd_valid && en && rnd.mode == f2p_pkg::MODE_ZERO |=> m_tdata == 32'd0)
    else $error("non-zero word for a zero-output item");

endmodule

// File: src/f2p_decode.sv
`timescale 1ns / 1ps

module f2p_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [31:0]       sample,
  input  logic              last,
  input  logic [2:0]        subframe_size,
  input  logic [5:0]        bit_depth,
  output logic              out_valid,
  output f2p_pkg::dec_t     dec
);

  f2p_pkg::dec_t dec_next;
  logic [7:0]    expo;
  logic [22:0]   frac;

  assign expo = sample[30:23];
  assign frac = sample[22:0];

  always_comb begin
    dec_next.sgn  = sample[31];
    dec_next.expo = expo;
    dec_next.mant = {1'b1, frac};
    dec_next.last = last;
    if (subframe_size == 3'd4 && bit_depth >= 6'd24) begin
      dec_next.mode = f2p_pkg::MODE_32;
    end else if (subframe_size == 3'd3) begin
      dec_next.mode = f2p_pkg::MODE_24;
    end else if (subframe_size == 3'd2) begin
      dec_next.mode = f2p_pkg::MODE_16;
    end else begin
      dec_next.mode = f2p_pkg::MODE_ZERO;
    end
    // NaN becomes +1; anything of magnitude one or more clamps to one.
    if (expo == f2p_pkg::EXP_SPECIAL && frac != 23'd0) begin
      dec_next.sgn  = 1'b0;
      dec_next.expo = f2p_pkg::EXP_ONE;
      dec_next.mant = 24'h80_0000;
    end else if (expo >= f2p_pkg::EXP_ONE) begin
      dec_next.expo = f2p_pkg::EXP_ONE;
      dec_next.mant = 24'h80_0000;
    end else if (expo == 8'd0) begin
      // Zeros and subnormals always truncate to zero.
      dec_next.mode = f2p_pkg::MODE_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec <= dec_next;
    end
  end

endmodule

// File: src/f2p_mul.sv
`timescale 1ns / 1ps

module f2p_mul (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  f2p_pkg::dec_t dec,
  output logic          out_valid,
  output f2p_pkg::mul_t mul
);

  logic [55:0] prod;

  assign prod = {32'd0, dec.mant} * {24'd0, f2p_pkg::scale_k(dec.mode)};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul.sgn  <= dec.sgn;
      mul.expo <= dec.expo;
      mul.prod <= prod;
      mul.mode <= dec.mode;
      mul.last <= dec.last;
    end
  end

endmodule

// File: src/f2p_round.sv
`timescale 1ns / 1ps

module f2p_round (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  f2p_pkg::mul_t mul,
  output logic          out_valid,
  output f2p_pkg::rnd_t rnd
);

  logic [4:0]        kb;
  logic [55:0]       hi;
  logic              carry;
  logic [5:0]        pos;
  logic [55:0]       below;
  logic [23:0]       keep;
  logic              guard;
  logic              sticky;
  logic              up;
  logic [24:0]       rmant;
  logic signed [9:0] shamt;

  // The product's leading one sits at 23 + kb or one above; keep 24 bits
  // from there and round to nearest even.
  always_comb begin
    kb     = f2p_pkg::scale_bit(mul.mode);
    hi     = mul.prod >> (6'd24 + {1'b0, kb});
    carry  = hi[0];
    pos    = {1'b0, kb} + {5'd0, carry};
    below  = mul.prod >> (pos - 6'd1);
    guard  = below[0];
    keep   = below[24:1];
    sticky = |(mul.prod & ((56'd1 << (pos - 6'd1)) - 56'd1));
    up     = guard && (sticky || keep[0]);
    rmant  = {1'b0, keep} + {24'd0, up};
    shamt  = $signed({4'd0, pos}) + $signed({2'd0, mul.expo}) - 10'sd150;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rnd.sgn   <= mul.sgn;
      rnd.rmant <= rmant;
      rnd.shamt <= shamt;
      rnd.mode  <= mul.mode;
      rnd.last  <= mul.last;
    end
  end

endmodule

// File: src/f2p_pack.sv
`timescale 1ns / 1ps

module f2p_pack (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  f2p_pkg::rnd_t rnd,
  output logic          out_valid,
  output logic [31:0]   pcm_word,
  output logic          last
);

  logic [9:0]  rs;
  logic [32:0] mag;
  logic [31:0] val;
  logic [31:0] pcm_next;

  always_comb begin
    rs = 10'd0 - rnd.shamt;
    if (!rnd.shamt[9]) begin
      mag = {8'd0, rnd.rmant} << rnd.shamt[3:0];
    end else if (rs >= 10'd25) begin
      mag = 33'd0;
    end else begin
      mag = {8'd0, rnd.rmant >> rs[4:0]};
    end
    if (rnd.sgn) begin
      val = 32'd0 - mag[31:0];
    end else if (mag >= 33'h0_8000_0000) begin
      val = 32'h7fff_ffff;
    end else begin
      val = mag[31:0];
    end
    unique case (rnd.mode)
      f2p_pkg::MODE_16: pcm_next = {16'd0, val[15:0]};
      f2p_pkg::MODE_24: pcm_next = {8'd0, val[23:0]};
      f2p_pkg::MODE_32: pcm_next = val;
      default:          pcm_next = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pcm_word <= pcm_next;
      last     <= rnd.last;
    end
  end

endmodule
